FILE: hdl/fibm_pkg.sv
// ---------------------------------------------------------------------------
// fibm_pkg - shared types and constants
// Field widths, operation/result records between the sequencer and the
// multiply-reduce unit, and the modulus and reciprocal tables.
// ---------------------------------------------------------------------------
package fibm_pkg;

  // Field widths
  localparam int SEED_W     = 16;
  localparam int INDEX_W    = 32;
  localparam int DIGIT_W    = 3;
  localparam int VAL_W      = 14;
  localparam int TAG_W      = 2;

  // Datapath widths inside the multiply-reduce unit
  localparam int PROD_W      = SEED_W + VAL_W;     // one product
  localparam int ACC_W       = PROD_W + 1;         // sum of two products
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = ACC_W;

  // Default for the top-level index width and the digit-count ceiling
  localparam int INDEX_BITS_DEF = 32;
  localparam int MAX_DIGITS     = 4;

  typedef logic [SEED_W-1:0]  seed_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [DIGIT_W-1:0] dsel_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // Matrix entry tags (row, column)
  localparam tag_t TAG_00 = 2'd0;
  localparam tag_t TAG_01 = 2'd1;
  localparam tag_t TAG_10 = 2'd2;
  localparam tag_t TAG_11 = 2'd3;

  // One operation: (x*y + u*v) mod 10^dsel
  typedef struct packed {
    logic  valid;
    tag_t  tag;
    dsel_t dsel;
    seed_t x;
    val_t  y;
    seed_t u;
    val_t  v;
  } op_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
    val_t value;
  } res_t;

  // 10^d, saturating at 10^4 for d of 4 and above
  function automatic val_t mod_of(input dsel_t d);
    unique case (d)
      3'd0:    mod_of = val_t'(1);
      3'd1:    mod_of = val_t'(10);
      3'd2:    mod_of = val_t'(100);
      3'd3:    mod_of = val_t'(1000);
      default: mod_of = val_t'(10000);
    endcase
  endfunction

  // floor(2^RECIP_SHIFT / 10^d)
  function automatic recip_t recip_of(input dsel_t d);
    unique case (d)
      3'd0:    recip_of = recip_t'(64'd2147483648);
      3'd1:    recip_of = recip_t'(64'd214748364);
      3'd2:    recip_of = recip_t'(64'd21474836);
      3'd3:    recip_of = recip_t'(64'd2147483);
      default: recip_of = recip_t'(64'd214748);
    endcase
  endfunction

endpackage

FILE: hdl/fibm_req_if.sv
// ---------------------------------------------------------------------------
// fibm_req_if - request channel
// Valid/ready channel carrying the seeds, the term index and the digit count.
// ---------------------------------------------------------------------------
interface fibm_req_if import fibm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SEED_W-1:0]    seed_first;
  logic [SEED_W-1:0]    seed_second;
  logic [INDEX_W-1:0]   term_index;
  logic [DIGIT_W-1:0]   digit_count;

  modport source (output valid, seed_first, seed_second, term_index, digit_count,
                  input ready);
  modport sink (input valid, seed_first, seed_second, term_index, digit_count,
                output ready);
endinterface

FILE: hdl/fibm_rsp_if.sv
// ---------------------------------------------------------------------------
// fibm_rsp_if - result channel
// Valid/ready channel carrying the trailing decimal digits of the term.
// ---------------------------------------------------------------------------
interface fibm_rsp_if import fibm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] term_digits;

  modport source (output valid, term_digits, input ready);
  modport sink (input valid, term_digits, output ready);
endinterface

FILE: hdl/fibm_modmac.sv
// ---------------------------------------------------------------------------
// fibm_modmac - pipelined modular multiply-accumulate
// Computes (x*y + u*v) mod 10^d in five stages, one operation per cycle.
// Reduction multiplies by a fixed-point reciprocal, then corrects once.
// ---------------------------------------------------------------------------
module fibm_modmac import fibm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  op_t  op,
  output res_t res
);

  logic                      v1, v2, v3, v4, v5;
  tag_t                      tag1, tag2, tag3, tag4, tag5;
  dsel_t                     d1, d2, d3, d4, d5;
  logic [PROD_W-1:0]         p1;
  seed_t                     u1;
  val_t                      w1;
  logic [ACC_W-1:0]          s2, s3;
  logic [ACC_W-1:0]          q3;
  logic [VAL_W:0]            r4;
  val_t                      out5;

  logic [PROD_W-1:0]         uv_prod;
  logic [ACC_W+RECIP_W-1:0]  q_prod;
  logic [ACC_W+VAL_W-1:0]    qm_prod;
  logic [ACC_W-1:0]          diff;
  val_t                      md4;

  assign uv_prod = u1 * w1;
  assign q_prod  = s2 * recip_of(d2);
  assign qm_prod = q3 * mod_of(d3);
  assign diff    = s3 - qm_prod[ACC_W-1:0];
  assign md4     = mod_of(d4);

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= op.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    // stage 1: first product
    p1   <= op.x * op.y;
    u1   <= op.u;
    w1   <= op.v;
    tag1 <= op.tag;
    d1   <= op.dsel;
    // stage 2: second product and sum
    s2   <= ACC_W'(p1) + ACC_W'(uv_prod);
    tag2 <= tag1;
    d2   <= d1;
    // stage 3: quotient estimate, low by at most one
    q3   <= q_prod[RECIP_SHIFT +: ACC_W];
    s3   <= s2;
    tag3 <= tag2;
    d3   <= d2;
    // stage 4: remainder, below twice the modulus
    r4   <= diff[VAL_W:0];
    tag4 <= tag3;
    d4   <= d3;
    // stage 5: final correction
    out5 <= (r4 >= {1'b0, md4}) ? VAL_W'(r4 - {1'b0, md4}) : r4[VAL_W-1:0];
    tag5 <= tag4;
    d5   <= d4;
  end

  assign res.valid = v5;
  assign res.tag   = tag5;
  assign res.value = out5;

  // Checks
  a_res_reduced: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (out5 < mod_of(d5)))
    else $error("result not reduced below modulus");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (r4 < ({1'b0, md4} + {1'b0, md4})))
    else $error("quotient estimate off by more than one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    v5 |-> $past(op.valid, 5))
    else $error("result without matching operation");

endmodule

FILE: hdl/fibm_seq.sv
// ---------------------------------------------------------------------------
// fibm_seq - square-and-multiply sequencer
// Holds the running matrix, walks the index bits from the top, issues the
// four entry products per square, folds in the step matrix with modular
// adds, and finishes with the seed combination.
// ---------------------------------------------------------------------------
module fibm_seq import fibm_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  fibm_req_if.sink   req,
  fibm_rsp_if.source rsp,
  output op_t        op,
  input  res_t       res
);

  localparam int BCNT_W = $clog2(INDEX_BITS);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ISSUE    = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_COMMIT   = 3'd3;
  localparam logic [2:0] ST_FIN      = 3'd4;
  localparam logic [2:0] ST_FIN_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT      = 3'd6;

  logic [2:0]            state;
  tag_t                  icnt;
  tag_t                  rcnt;
  logic [BCNT_W-1:0]     bcnt;
  logic [INDEX_BITS-1:0] nsh;
  dsel_t                 dsel;
  seed_t                 seed_a, seed_b;
  val_t                  r    [4];
  val_t                  prod [4];
  val_t                  fin;
  logic                  out_valid;
  val_t                  out_data;

  dsel_t dsel_in;
  val_t  md_cur;
  val_t  one_in;

  // (a + b) mod md, both inputs already reduced
  function automatic val_t madd(input val_t a, input val_t b, input val_t md);
    logic [VAL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    madd = (sum >= {1'b0, md}) ? VAL_W'(sum - {1'b0, md}) : sum[VAL_W-1:0];
  endfunction

  // Digit count saturates at the ceiling
  assign dsel_in = (req.digit_count > dsel_t'(MAX_DIGITS)) ? dsel_t'(MAX_DIGITS)
                                                           : req.digit_count;
  assign one_in  = (mod_of(dsel_in) == val_t'(1)) ? val_t'(0) : val_t'(1);
  assign md_cur  = mod_of(dsel);

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.term_digits = out_data;

  // Operand select for the shared unit
  always_comb begin
    op.valid = (state == ST_ISSUE) || (state == ST_FIN);
    op.tag   = (state == ST_FIN) ? TAG_00 : icnt;
    op.dsel  = dsel;
    op.x     = seed_t'(r[0]);
    op.y     = r[0];
    op.u     = seed_t'(r[1]);
    op.v     = r[2];
    if (state == ST_FIN) begin
      op.x = seed_a;
      op.y = r[0];
      op.u = seed_b;
      op.v = r[1];
    end else begin
      case (icnt)
        TAG_00: begin
          op.x = seed_t'(r[0]); op.y = r[0];
          op.u = seed_t'(r[1]); op.v = r[2];
        end
        TAG_01: begin
          op.x = seed_t'(r[0]); op.y = r[1];
          op.u = seed_t'(r[1]); op.v = r[3];
        end
        TAG_10: begin
          op.x = seed_t'(r[2]); op.y = r[0];
          op.u = seed_t'(r[3]); op.v = r[2];
        end
        default: begin
          op.x = seed_t'(r[2]); op.y = r[1];
          op.u = seed_t'(r[3]); op.v = r[3];
        end
      endcase
    end
  end

  // Returned entries land by tag
  always_ff @(posedge clk) begin
    if (res.valid) begin
      prod[res.tag] <= res.value;
    end
  end

  // Output register valid: set on load, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      icnt      <= TAG_00;
      rcnt      <= TAG_00;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            seed_a <= req.seed_first;
            seed_b <= req.seed_second;
            nsh    <= INDEX_BITS'(req.term_index);
            dsel   <= dsel_in;
            bcnt   <= BCNT_W'(INDEX_BITS - 1);
            r[0]   <= one_in;
            r[1]   <= val_t'(0);
            r[2]   <= val_t'(0);
            r[3]   <= one_in;
            icnt   <= TAG_00;
            rcnt   <= TAG_00;
            state  <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          icnt <= icnt + tag_t'(1);
          if (icnt == TAG_11) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // count returned entries; the fourth ends the square
          if (res.valid) begin
            rcnt <= rcnt + tag_t'(1);
            if (rcnt == TAG_11) begin
              state <= ST_COMMIT;
            end
          end
        end
        ST_COMMIT: begin
          // square done; multiply by [[0,1],[1,1]] when the bit is set
          if (nsh[INDEX_BITS-1]) begin
            r[0] <= prod[1];
            r[1] <= madd(prod[0], prod[1], md_cur);
            r[2] <= prod[3];
            r[3] <= madd(prod[2], prod[3], md_cur);
          end else begin
            r[0] <= prod[0];
            r[1] <= prod[1];
            r[2] <= prod[2];
            r[3] <= prod[3];
          end
          nsh  <= nsh << 1;
          icnt <= TAG_00;
          rcnt <= TAG_00;
          if (bcnt == '0) begin
            state <= ST_FIN;
          end else begin
            bcnt  <= bcnt - BCNT_W'(1);
            state <= ST_ISSUE;
          end
        end
        ST_FIN: begin
          state <= ST_FIN_WAIT;
        end
        ST_FIN_WAIT: begin
          if (res.valid) begin
            fin   <= res.value;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_data  <= fin;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_res_window: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_WAIT || state == ST_FIN_WAIT))
    else $error("unit result outside a wait state");

  a_commit_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |=> (r[0] < md_cur && r[1] < md_cur &&
                            r[2] < md_cur && r[3] < md_cur))
    else $error("matrix entry not reduced after commit");

  a_start: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> (state == ST_ISSUE && rcnt == TAG_00 && icnt == TAG_00))
    else $error("request did not start a square pass");

endmodule

FILE: hdl/fibonacci_mod_pow10_matrix_power.sv
// ---------------------------------------------------------------------------
// fibonacci_mod_pow10_matrix_power - generalized Fibonacci term, last digits
// Returns f(n) mod 10^m for f(0)=a, f(1)=b by raising [[0,1],[1,1]] to the
// power n with square-and-multiply, then combining with the seeds.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   seed_first, seed_second, term_index, digit_count
//   rsp      out  valid/ready   term_digits
//
// The time from the accepting edge to rsp.valid does not depend on the index
// value; a new request is taken only once the previous result has been
// loaded into the output register.
// For each index bit the four entry products are issued, the sequencer waits
// until the last entry leaves the multiply-reduce pipeline, and then commits;
// the seed combination adds one issue, the pipeline wait and an output step.
// req.ready is high only while idle; a finished result waits in the output
// register and the next request is taken while it waits. A second finished
// result holds the sequencer until the first is taken, stalling req.
// Reset is synchronous and clears the sequencer, the output valid flag and the unit's valid pipeline.
//
module fibonacci_mod_pow10_matrix_power import fibm_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fibm_req_if.sink   req,
  fibm_rsp_if.source rsp
);

  op_t  op;
  res_t res;

  // Sequencer and matrix state
  fibm_seq #(
    .INDEX_BITS (INDEX_BITS)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .op  (op),
    .res (res)
  );

  // Shared multiply-reduce unit
  fibm_modmac u_modmac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .res (res)
  );

endmodule
